// File: src/b36fmt_pkg.sv
package b36fmt_pkg;

    localparam int DIGIT_SLOTS  = 6;
    localparam int DIGIT_IDX_W  = 3;
    localparam int DIGIT_W      = 6;
    localparam int VALUE_W      = 31;
    localparam int CHAR_W       = 7;
    localparam int PAD_W        = 5;
    localparam int MAX_PAD_DEF  = 16;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [PAD_W-1:0] PAD_RESET = 5'd4;

    // Register index of pad_length
    localparam logic REG_PAD_LENGTH = 1'b0;

    // ceil(2^33 / 9): x / 9 == (x * RECIP9) >> 33 for any x below 2^32
    localparam logic [29:0] RECIP9 = 30'h38E3_8E39;
    localparam int          RECIP_SHIFT = 33;

    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'h37;  // 'A' - 10

    typedef struct packed {
        logic load;
        logic div_step;
        logic emit_step;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
        logic emit_last;
    } t_dp_status;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    // Map a base-36 digit to its ASCII symbol
    function automatic logic [CHAR_W-1:0] f_symbol(input logic [DIGIT_W-1:0] digit);
        logic [CHAR_W-1:0] d;
        d = {1'b0, digit};
        if (digit < 6'd10) begin
            f_symbol = CHAR_ZERO + d;
        end else begin
            f_symbol = CHAR_LETTER + d;
        end
    endfunction

endpackage

// File: src/b36fmt_ctrl.sv
module b36fmt_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  b36fmt_pkg::t_dp_status i_status,
    output b36fmt_pkg::t_dp_cmd   o_cmd,
    output logic                  o_busy
);
    import b36fmt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_status.div_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy         = (r_state != ST_IDLE);
    assign o_cmd.load     = (r_state == ST_IDLE) && i_start;
    assign o_cmd.div_step = (r_state == ST_DIV);
    assign o_cmd.emit_step = (r_state == ST_EMIT);

endmodule

// File: src/b36fmt_dp.sv
module b36fmt_dp #(
    parameter int MAX_PAD = b36fmt_pkg::MAX_PAD_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  b36fmt_pkg::t_dp_cmd               i_cmd,
    input  logic [b36fmt_pkg::VALUE_W-1:0]    i_value,
    input  logic [$clog2(((MAX_PAD > b36fmt_pkg::DIGIT_SLOTS) ? MAX_PAD
                          : b36fmt_pkg::DIGIT_SLOTS) + 1)-1:0] i_pad,
    output b36fmt_pkg::t_dp_status            o_status,
    output logic                              o_valid,
    output logic [b36fmt_pkg::CHAR_W-1:0]     o_char,
    output logic                              o_last
);
    import b36fmt_pkg::*;

    localparam int TOTAL_MAX = (MAX_PAD > DIGIT_SLOTS) ? MAX_PAD : DIGIT_SLOTS;
    localparam int CNT_W     = $clog2(TOTAL_MAX + 1);
    localparam int PROD_W    = 59;
    localparam int QUOT_W    = 26;

    logic [VALUE_W-1:0]  r_quot;
    logic [DIGIT_W-1:0]  r_digits [DIGIT_SLOTS];
    logic [DIGIT_IDX_W-1:0] r_cnt;
    logic [CNT_W-1:0]    r_rem;
    logic                r_valid;
    logic [CHAR_W-1:0]   r_char;
    logic                r_last;

    logic [PROD_W-1:0]   prod;
    logic [QUOT_W-1:0]   quot_next;
    logic [VALUE_W-1:0]  times36;
    logic [VALUE_W-1:0]  diff;
    logic [DIGIT_W-1:0]  digit_new;
    logic [CNT_W-1:0]    cnt_inc;
    logic [CNT_W-1:0]    cnt_ext;
    logic [CNT_W-1:0]    rem_dec;
    logic [CHAR_W-1:0]   char_sel;

    // Divide by 36 as (x >> 2) / 9 through a reciprocal multiply
    assign prod      = PROD_W'(r_quot[VALUE_W-1:2]) * PROD_W'(RECIP9);
    assign quot_next = prod[RECIP_SHIFT +: QUOT_W];
    assign times36   = VALUE_W'({quot_next, 5'b0}) + VALUE_W'({quot_next, 2'b0});
    assign diff      = r_quot - times36;
    assign digit_new = diff[DIGIT_W-1:0];

    assign cnt_ext = CNT_W'(r_cnt);
    assign cnt_inc = cnt_ext + CNT_W'(1);
    assign rem_dec = r_rem - CNT_W'(1);

    // Leading zeros while more characters remain than digits
    always_comb begin
        if (r_rem > cnt_ext) begin
            char_sel = CHAR_ZERO;
        end else begin
            char_sel = f_symbol(r_digits[rem_dec[DIGIT_IDX_W-1:0]]);
        end
    end

    assign o_status.div_last  = (quot_next == '0);
    assign o_status.emit_last = (r_rem == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit_step;
            if (i_cmd.load) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + DIGIT_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quot <= i_value;
        end else if (i_cmd.div_step) begin
            r_quot          <= VALUE_W'(quot_next);
            r_digits[r_cnt] <= digit_new;
            if (quot_next == '0) begin
                r_rem <= (cnt_inc > i_pad) ? cnt_inc : i_pad;
            end
        end else if (i_cmd.emit_step) begin
            r_rem <= rem_dec;
        end
        if (i_cmd.emit_step) begin
            r_char <= char_sel;
            r_last <= (r_rem == CNT_W'(1));
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;

endmodule

// File: src/base36_number_formatter_unit.sv
// Base-36 formatter: one 31-bit value in, its ASCII digits out, most significant first.
// Operation: start accepted, then one divide-by-36 step per significant digit (N = 1..6),
// then one character per cycle for T = max(N, pad) characters, each registered once.
// A new request is taken only when idle, as the single shared divide step and the
// character output register serve one request at a time; the receiver cannot stall.
// Reset (synchronous, active low): idle, no output strobe, pad_length back to 4.
module base36_number_formatter_unit #(
    parameter int MAX_PAD = b36fmt_pkg::MAX_PAD_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request channel
    input  logic                               start,
    output logic                               busy,
    input  logic [b36fmt_pkg::VALUE_W-1:0]     i_value,
    // character stream
    output logic                               o_out_valid,
    output logic [b36fmt_pkg::CHAR_W-1:0]      o_out_char,
    output logic                               o_is_last,
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [b36fmt_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [b36fmt_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [b36fmt_pkg::APB_DATA_W-1:0]  prdata,
    output logic                               pready
);
    import b36fmt_pkg::*;

    localparam int TOTAL_MAX = (MAX_PAD > DIGIT_SLOTS) ? MAX_PAD : DIGIT_SLOTS;
    localparam int CNT_W     = $clog2(TOTAL_MAX + 1);

    logic [PAD_W-1:0] r_pad;
    logic [CNT_W-1:0] pad_sat;
    logic             reg_hit;
    logic             apb_write;
    t_dp_cmd          cmd;
    t_dp_status       status;

    // Register file: a single register at byte address zero
    assign pready    = 1'b1;
    assign reg_hit   = (paddr[2] == REG_PAD_LENGTH);
    assign apb_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad <= PAD_RESET;
        end else if (apb_write && reg_hit) begin
            // drop writes to any other index
            r_pad <= pwdata[PAD_W-1:0];
        end
    end

    assign prdata = reg_hit ? APB_DATA_W'(r_pad) : '0;

    // Clamp the pad length to the widest string the counters allow
    always_comb begin
        if (32'(r_pad) > 32'(MAX_PAD)) begin
            pad_sat = CNT_W'(MAX_PAD);
        end else begin
            pad_sat = CNT_W'(r_pad);
        end
    end

    // Sequencer: idle, divide, emit
    b36fmt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // Quotient register, digit store, character counter and output register
    b36fmt_dp #(
        .MAX_PAD (MAX_PAD)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_value  (i_value),
        .i_pad    (pad_sat),
        .o_status (status),
        .o_valid  (o_out_valid),
        .o_char   (o_out_char),
        .o_last   (o_is_last)
    );

endmodule
